FILE: rtl/core/gait_foot_target_generator_core_assert.svh
// Assertion macros for the core's RTL; gftg_queue is the file that includes them.
// Each macro expects clk and rst in scope.
`ifndef GAIT_FOOT_TARGET_GENERATOR_CORE_ASSERT_SVH
`define GAIT_FOOT_TARGET_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define GFTG_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GFTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gftg_pkg.sv
// ----------------------------------------------------------------------------
// gftg_pkg
// Types, constants and helper functions of the gait foot target core.
// ----------------------------------------------------------------------------
`default_nettype none

package gftg_pkg;

  localparam int SINE_TABLE_BITS_DEF = 8;
  localparam int FREQ_FLOOR_MHZ      = 10;
  localparam int QUEUE_DEPTH         = 2;
  localparam int DIV_W               = 30;   // quotient bits of the step divider

  // register indexes
  localparam logic [2:0] REG_GAIT_FREQ   = 3'd0;
  localparam logic [2:0] REG_STANCE_DUTY = 3'd1;
  localparam logic [2:0] REG_STEP_LEN    = 3'd2;
  localparam logic [2:0] REG_LAT_STEP    = 3'd3;
  localparam logic [2:0] REG_TURN_STEP   = 3'd4;
  localparam logic [2:0] REG_STEP_HEIGHT = 3'd5;

  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // floor(a / 625) == (a * RECIP_625) >> RECIP_SHIFT for a < 2^29
  localparam logic [29:0] RECIP_625   = 30'd879609303;
  localparam int          RECIP_SHIFT = 39;

  typedef struct packed {
    logic signed [15:0] nominal_x;
    logic signed [15:0] nominal_y;
    logic signed [15:0] nominal_z;
    logic               phase_is_swing;
    logic        [16:0] phase_frac;
    logic signed [15:0] lin_vel_x;
    logic signed [15:0] lin_vel_y;
    logic signed [15:0] yaw_rate;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_z;
  } result_t;

  typedef struct packed {
    logic [15:0] gait_frequency_mhz;
    logic [16:0] stance_duty_q16;
    logic [14:0] step_length_limit;
    logic [14:0] lateral_step_limit;
    logic [14:0] turn_step_limit;
    logic [14:0] step_height;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic signed [15:0] nominal_x;
    logic signed [15:0] nominal_y;
    logic signed [15:0] nominal_z;
    logic               phase_is_swing;
    logic signed [18:0] sweep;        // +-(65536 - 2*fraction)
    logic        [16:0] lift;         // sin(pi*fraction), Q16
    logic   [2:0][15:0] vel_mag;      // x, y, yaw magnitudes
    logic        [2:0]  vel_neg;
  } entry_t;

  // sin(pi * idx / 2^(bits+1)) in Q16, odd Taylor series in Q30
  function automatic logic [16:0] lift_entry(input int unsigned idx, input int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] r;
    x  = (64'(idx) * HALF_PI_Q30) >> bits;
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    if (s > ONE_Q30) s = ONE_Q30;
    r  = (s + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return r[16:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
    return (v > 24'sd32767) ? 16'sh7fff :
           (v < -24'sd32768) ? 16'sh8000 : v[15:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gftg_front.sv
// ----------------------------------------------------------------------------
// gftg_front
// Accepts an item, folds the phase, looks up the lift and splits velocities.
// ----------------------------------------------------------------------------
`default_nettype none

module gftg_front #(
  parameter int SINE_TABLE_BITS = gftg_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire logic            start,
  input  wire logic            full,
  input  wire gftg_pkg::cmd_t  cmd,
  output logic                 busy,
  output logic                 push,
  output gftg_pkg::entry_t     entry
);
  import gftg_pkg::*;

  localparam int TBL_N = (1 << SINE_TABLE_BITS) + 1;
  localparam int IDX_W = SINE_TABLE_BITS + 1;

  logic [16:0] lift_rom [TBL_N];

  for (genvar gi = 0; gi < TBL_N; gi++) begin : g_rom
    assign lift_rom[gi] = lift_entry(gi, SINE_TABLE_BITS);
  end

  logic        [16:0]                 frac_sat;
  logic        [15:0]                 half_frac;
  logic        [SINE_TABLE_BITS+15:0] idx_wide;
  logic        [IDX_W-1:0]            idx;
  logic signed [18:0]                 c_stance;
  logic signed [2:0][15:0]            vel;

  assign busy = full;
  assign push = start && !full;

  always_comb begin
    frac_sat  = (cmd.phase_frac > 17'd65536) ? 17'd65536 : cmd.phase_frac;
    half_frac = (frac_sat > 17'd32768) ? 16'(17'd65536 - frac_sat) : frac_sat[15:0];
    idx_wide  = {half_frac, {SINE_TABLE_BITS{1'b0}}}
              + (SINE_TABLE_BITS + 16)'(16384);
    idx       = idx_wide[SINE_TABLE_BITS+15:15];
    c_stance  = $signed(19'd65536) - $signed({1'b0, cmd.phase_frac, 1'b0});

    vel[0] = cmd.lin_vel_x;
    vel[1] = cmd.lin_vel_y;
    vel[2] = cmd.yaw_rate;

    entry.nominal_x      = cmd.nominal_x;
    entry.nominal_y      = cmd.nominal_y;
    entry.nominal_z      = cmd.nominal_z;
    entry.phase_is_swing = cmd.phase_is_swing;
    entry.sweep          = cmd.phase_is_swing ? -c_stance : c_stance;
    entry.lift           = lift_rom[idx];
    for (int i = 0; i < 3; i++) begin
      entry.vel_neg[i] = vel[i][15];
      entry.vel_mag[i] = vel[i][15] ? (~vel[i] + 16'd1) : vel[i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/gftg_queue.sv
// ----------------------------------------------------------------------------
// gftg_queue
// Small FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gftg_queue #(
  parameter int DEPTH = gftg_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire gftg_pkg::entry_t  din,
  input  wire logic              pop,
  output gftg_pkg::entry_t       dout,
  output logic                   full,
  output logic                   empty
);
  import gftg_pkg::*;

  `include "gait_foot_target_generator_core_assert.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   cnt;

  assign full  = (cnt == CNT_W'(DEPTH));
  assign empty = (cnt == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  `GFTG_ASSERT_IMPLIES(a_push_not_full, push, cnt < CNT_W'(DEPTH), "push into full queue")
  `GFTG_ASSERT_IMPLIES(a_pop_not_empty, pop, cnt != '0, "pop from empty queue")
  `GFTG_ASSERT_NEXT(a_cnt_up, push && !pop, cnt == $past(cnt) + 1'b1, "queue count lost a push")

endmodule

`default_nettype wire

FILE: rtl/core/gftg_div.sv
// ----------------------------------------------------------------------------
// gftg_div
// Pipelined restoring divider, one quotient bit per stage, 16-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module gftg_div #(
  parameter int NW = gftg_pkg::DIV_W
) (
  input  wire logic          clk,
  input  wire logic [NW-1:0] num,
  input  wire logic [15:0]   den,
  output logic      [NW-1:0] quo
);

  logic [15:0]   rem_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [NW-1:0] quo_q [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [15:0]   prev_rem;
    logic [NW-1:0] prev_num;
    logic [NW-1:0] prev_quo;
    logic [16:0]   trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign prev_rem = '0;
      assign prev_num = num;
      assign prev_quo = '0;
    end else begin : g_next
      assign prev_rem = rem_q[s-1];
      assign prev_num = num_q[s-1];
      assign prev_quo = quo_q[s-1];
    end

    assign trial = {prev_rem, prev_num[NW-1]};
    assign ge    = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      rem_q[s] <= ge ? 16'(trial - {1'b0, den}) : trial[15:0];
      num_q[s] <= {prev_num[NW-2:0], 1'b0};
      quo_q[s] <= {prev_quo[NW-2:0], ge};
    end
  end

  assign quo = quo_q[NW-1];

endmodule

`default_nettype wire

FILE: rtl/core/gftg_back.sv
// ----------------------------------------------------------------------------
// gftg_back
// Step divide, sweep, rotation and saturation pipeline, one item per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gftg_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire gftg_pkg::cfg_t    cfg,
  input  wire logic              in_valid,
  input  wire gftg_pkg::entry_t  entry,
  output logic                   done,
  output gftg_pkg::result_t      result
);
  import gftg_pkg::*;

  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [16:0] z;
    logic signed [18:0] sweep;
    logic        [2:0]  neg;
  } side_t;

  logic [15:0] f_floor;
  assign f_floor = (cfg.gait_frequency_mhz < 16'(FREQ_FLOOR_MHZ)) ?
                   16'(FREQ_FLOOR_MHZ) : cfg.gait_frequency_mhz;

  logic [2:0][14:0] lim;
  assign lim[0] = cfg.step_length_limit;
  assign lim[1] = cfg.lateral_step_limit;
  assign lim[2] = cfg.turn_step_limit;

  // P0: velocity * duty, height * lift
  logic             v_p0;
  logic [2:0][32:0] p0_vd;
  logic [31:0]      p0_lh;
  entry_t           p0_e;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p0_vd[i] <= 33'(entry.vel_mag[i]) * 33'(cfg.stance_duty_q16);
    end
    p0_lh <= 32'(cfg.step_height) * 32'(entry.lift);
    p0_e  <= entry;
  end

  // P1: scale to divider numerator, add rounding half, z sum
  logic             v_p1;
  logic [2:0][DIV_W-1:0] p1_num;
  side_t            p1_side;
  logic [45:0]      p1_wide [3];
  logic signed [16:0] p1_lift;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p1_wide[i] = 46'(p0_vd[i]) * 46'd10000 + 46'({f_floor, 15'b0});
    end
    p1_lift = p0_e.phase_is_swing ? $signed({1'b0, 16'((33'(p0_lh) + 33'd32768) >> 16)})
                                  : 17'sd0;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p1_num[i] <= p1_wide[i][45:16];
    end
    p1_side.nx    <= p0_e.nominal_x;
    p1_side.ny    <= p0_e.nominal_y;
    p1_side.z     <= 17'(p0_e.nominal_z) + p1_lift;
    p1_side.sweep <= p0_e.sweep;
    p1_side.neg   <= p0_e.vel_neg;
  end

  // divider lanes and matching side line
  logic [2:0][DIV_W-1:0] quo;
  side_t                 dl_side [DIV_W];
  logic [DIV_W-1:0]      dl_v;

  for (genvar gl = 0; gl < 3; gl++) begin : g_lane
    gftg_div #(.NW(DIV_W)) u_div (
      .clk (clk),
      .num (p1_num[gl]),
      .den (f_floor),
      .quo (quo[gl])
    );
  end

  always_ff @(posedge clk) begin
    dl_side[0] <= p1_side;
    for (int k = 1; k < DIV_W; k++) begin
      dl_side[k] <= dl_side[k-1];
    end
  end

  // B1: clamp and sign
  logic                    v_b1;
  logic signed [2:0][15:0] b1_step;
  side_t                   b1_side;
  logic [14:0]             b1_mag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b1_mag[i] = (quo[i] > DIV_W'(lim[i])) ? lim[i] : quo[i][14:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      b1_step[i] <= dl_side[DIV_W-1].neg[i] ? -$signed({1'b0, b1_mag[i]})
                                             :  $signed({1'b0, b1_mag[i]});
    end
    b1_side <= dl_side[DIV_W-1];
  end

  // B2: step * sweep (a packed element select is unsigned, so re-sign it)
  logic                    v_b2;
  logic signed [34:0]      b2_prod [3];
  side_t                   b2_side;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      b2_prod[i] <= 35'($signed(b1_step[i])) * 35'(b1_side.sweep);
    end
    b2_side <= b1_side;
  end

  // B3: round by 2^17 and offset the nominal point
  logic               v_b3;
  logic signed [19:0] b3_x;
  logic signed [19:0] b3_y;
  logic signed [19:0] b3_turn;
  logic signed [16:0] b3_z;
  logic [34:0]        b3_mag [3];
  logic [35:0]        b3_sum [3];
  logic signed [19:0] b3_off [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b3_mag[i] = b2_prod[i][34] ? 35'(-b2_prod[i]) : 35'(b2_prod[i]);
      b3_sum[i] = 36'(b3_mag[i]) + 36'd65536;
      b3_off[i] = b2_prod[i][34] ? -$signed({1'b0, b3_sum[i][35:17]})
                                 :  $signed({1'b0, b3_sum[i][35:17]});
    end
  end

  always_ff @(posedge clk) begin
    b3_x    <= 20'(b2_side.nx) + b3_off[0];
    b3_y    <= 20'(b2_side.ny) + b3_off[1];
    b3_turn <= b3_off[2];
    b3_z    <= b2_side.z;
  end

  // B4: rotation products (lane 0: y*turn, lane 1: x*turn)
  logic               v_b4;
  logic signed [39:0] b4_prod [2];
  logic signed [19:0] b4_x;
  logic signed [19:0] b4_y;
  logic signed [16:0] b4_z;

  always_ff @(posedge clk) begin
    b4_prod[0] <= 40'(b3_y) * 40'(b3_turn);
    b4_prod[1] <= 40'(b3_x) * 40'(b3_turn);
    b4_x       <= b3_x;
    b4_y       <= b3_y;
    b4_z       <= b3_z;
  end

  // B5: (|p| + 5000) / 10000 as ((|p|+5000) >> 4) * reciprocal of 625
  logic               v_b5;
  logic [58:0]        b5_q [2];
  logic [1:0]         b5_neg;
  logic signed [19:0] b5_x;
  logic signed [19:0] b5_y;
  logic signed [16:0] b5_z;
  logic [39:0]        b5_mag [2];
  logic [40:0]        b5_a [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      b5_mag[i] = b4_prod[i][39] ? 40'(-b4_prod[i]) : 40'(b4_prod[i]);
      b5_a[i]   = 41'(b5_mag[i]) + 41'd5000;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      b5_q[i]   <= 59'(b5_a[i][32:4]) * 59'(RECIP_625);
      b5_neg[i] <= b4_prod[i][39];
    end
    b5_x <= b4_x;
    b5_y <= b4_y;
    b5_z <= b4_z;
  end

  // B6: apply rotation terms and saturate
  logic [19:0]        b6_t [2];
  logic signed [20:0] b6_term [2];
  logic signed [21:0] b6_rx;
  logic signed [21:0] b6_ry;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      b6_t[i]    = b5_q[i][58:RECIP_SHIFT];
      b6_term[i] = b5_neg[i] ? -$signed({1'b0, b6_t[i]}) : $signed({1'b0, b6_t[i]});
    end
    b6_rx = 22'(b5_x) - 22'(b6_term[0]);
    b6_ry = 22'(b5_y) + 22'(b6_term[1]);
  end

  always_ff @(posedge clk) begin
    result.target_x <= sat16(24'(b6_rx));
    result.target_y <= sat16(24'(b6_ry));
    result.target_z <= sat16(24'(b5_z));
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v_p0 <= 1'b0;
      v_p1 <= 1'b0;
      dl_v <= '0;
      v_b1 <= 1'b0;
      v_b2 <= 1'b0;
      v_b3 <= 1'b0;
      v_b4 <= 1'b0;
      v_b5 <= 1'b0;
      done <= 1'b0;
    end else begin
      v_p0 <= in_valid;
      v_p1 <= v_p0;
      dl_v <= {dl_v[DIV_W-2:0], v_p1};
      v_b1 <= dl_v[DIV_W-1];
      v_b2 <= v_b1;
      v_b3 <= v_b2;
      v_b4 <= v_b3;
      v_b5 <= v_b4;
      done <= v_b5;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/gait_foot_target_generator_core.sv
// ----------------------------------------------------------------------------
// gait_foot_target_generator_core
// Foot target for one leg: stance/swing sweep, swing lift, small-angle turn.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive cmd and raise start; the item is taken at a rising
//   edge with start high and busy low. A new item may follow every cycle.
//   Result channel: done strobes for one cycle with result valid; there is
//   no backpressure, the receiver must take it in that cycle.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data. Writes
//   are always accepted; unknown indexes are dropped. Write only while no
//   item is in flight.
//   Pipeline: the queue, two scaling stages, the 30-stage step divider (one
//   quotient bit per stage) and six sweep/rotate/saturate stages.
//   Throughput: one item per cycle.
//   Reset (rst, synchronous): registers return to defaults, the queue and
//   all pipeline valids clear; items in flight are dropped.
//   busy rises only if the front queue fills, which the back never lets
//   happen since it drains an item every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gait_foot_target_generator_core #(
  parameter int SINE_TABLE_BITS = gftg_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire gftg_pkg::cmd_t     cmd,
  output logic                    done,
  output gftg_pkg::result_t       result,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [16:0]        cfg_data
);
  import gftg_pkg::*;

  // config register file
  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gait_frequency_mhz <= 16'd1000;
      cfg.stance_duty_q16    <= 17'd32768;
      cfg.step_length_limit  <= 15'd500;
      cfg.lateral_step_limit <= 15'd300;
      cfg.turn_step_limit    <= 15'd2000;
      cfg.step_height        <= 15'd300;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIT_FREQ:   cfg.gait_frequency_mhz <= cfg_data[15:0];
        REG_STANCE_DUTY: cfg.stance_duty_q16    <= cfg_data;
        REG_STEP_LEN:    cfg.step_length_limit  <= cfg_data[14:0];
        REG_LAT_STEP:    cfg.lateral_step_limit <= cfg_data[14:0];
        REG_TURN_STEP:   cfg.turn_step_limit    <= cfg_data[14:0];
        REG_STEP_HEIGHT: cfg.step_height        <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // front: accept, fold phase, lift lookup
  logic   push;
  logic   q_full;
  logic   q_empty;
  entry_t f_entry;
  entry_t q_entry;

  gftg_front #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_front (
    .start (start),
    .full  (q_full),
    .cmd   (cmd),
    .busy  (busy),
    .push  (push),
    .entry (f_entry)
  );

  // queue decouples accept from the back pipeline
  gftg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_entry),
    .pop   (!q_empty),
    .dout  (q_entry),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: never stalls, drains one item per cycle
  gftg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (!q_empty),
    .entry    (q_entry),
    .done     (done),
    .result   (result)
  );

endmodule

`default_nettype wire

FILE: tb/tb_gait_foot_target_generator_core.sv
// ----------------------------------------------------------------------------
// tb_gait_foot_target_generator_core
// Self-checking bench: directed table plus random items, compared in order
// against typed values or an in-bench predictor, across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gait_foot_target_generator_core;
  import gftg_pkg::*;

  localparam int LATENCY    = 38;
  localparam int WATCHDOG   = 5000;
  localparam int N_RANDOM   = 1150;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  cmd_t        cmd;
  logic        done;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [16:0] cfg_data;

  gait_foot_target_generator_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor's copy of the registers
  longint unsigned freq_mhz, duty_q16, lim_x, lim_y, lim_turn, lift_peak;

  result_t target_queue[$];
  int      errors;
  int      items_sent;
  int      targets_seen;
  int      idle_cycles;
  int      idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Round to nearest, ties away from zero (d > 0)
  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // sin(pi*frac) in Q16 via quarter-wave fold, quantized table index, Q30 Taylor
  function automatic longint unsigned swing_lift(longint unsigned frac);
    longint unsigned h, idx, x, x2, t, s, r;
    if (frac > 65536) frac = 65536;
    h   = (frac > 32768) ? 65536 - frac : frac;
    idx = ((h << 8) + 16384) >> 15;
    x   = (idx * 64'd1686629713) >> 8;
    x2  = (x * x) >> 30;
    t   = 64'd1073741824 - x2 / 110;
    t   = 64'd1073741824 - ((x2 * t) >> 30) / 72;
    t   = 64'd1073741824 - ((x2 * t) >> 30) / 42;
    t   = 64'd1073741824 - ((x2 * t) >> 30) / 20;
    t   = 64'd1073741824 - ((x2 * t) >> 30) / 6;
    s   = (x * t) >> 30;
    if (s > 64'd1073741824) s = 64'd1073741824;
    r   = (s + 8192) >> 14;
    if (r > 65536) r = 65536;
    return r;
  endfunction

  // Velocity times stance time, clamped
  function automatic longint stance_step(longint v, longint lim);
    longint f;
    f = (freq_mhz < FREQ_FLOOR_MHZ) ? FREQ_FLOOR_MHZ : longint'(freq_mhz);
    return clamp_mag(round_div(v * longint'(duty_q16) * 10000, f * 65536), lim);
  endfunction

  function automatic result_t foot_target(cmd_t c);
    longint sx, sy, st, sweep, x, y, z, turn;
    result_t r;
    sx    = stance_step(longint'(c.lin_vel_x), lim_x);
    sy    = stance_step(longint'(c.lin_vel_y), lim_y);
    st    = stance_step(longint'(c.yaw_rate), lim_turn);
    sweep = 65536 - 2 * longint'(c.phase_frac);
    if (c.phase_is_swing) sweep = -sweep;
    x    = longint'(c.nominal_x) + round_div(sx * sweep, 131072);
    y    = longint'(c.nominal_y) + round_div(sy * sweep, 131072);
    turn = round_div(st * sweep, 131072);
    z    = longint'(c.nominal_z);
    if (c.phase_is_swing)
      z += longint'((lift_peak * swing_lift(c.phase_frac) + 32768) >> 16);
    r.target_x = clip16(x - round_div(y * turn, 10000));
    r.target_y = clip16(y + round_div(x * turn, 10000));
    r.target_z = clip16(z);
    return r;
  endfunction

  // Result checker: done strobes cannot be held off, sample every edge
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      targets_seen <= targets_seen + 1;
      if (target_queue.size() == 0) begin
        $error("unexpected target x=%0d y=%0d z=%0d",
               result.target_x, result.target_y, result.target_z);
        errors++;
      end else begin
        want = target_queue.pop_front();
        if (result.target_x !== want.target_x) begin
          $error("target_x expected %0d actual %0d", want.target_x, result.target_x);
          errors++;
        end
        if (result.target_y !== want.target_y) begin
          $error("target_y expected %0d actual %0d", want.target_y, result.target_y);
          errors++;
        end
        if (result.target_z !== want.target_z) begin
          $error("target_z expected %0d actual %0d", want.target_z, result.target_z);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no item, target or register write moving
  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("[gait_foot_target_generator_core] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, longint unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[16:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GAIT_FREQ:   freq_mhz  = val & 16'hffff;
      REG_STANCE_DUTY: duty_q16  = val & 17'h1ffff;
      REG_STEP_LEN:    lim_x     = val & 15'h7fff;
      REG_LAT_STEP:    lim_y     = val & 15'h7fff;
      REG_TURN_STEP:   lim_turn  = val & 15'h7fff;
      REG_STEP_HEIGHT: lift_peak = val & 15'h7fff;
      default: ;
    endcase
  endtask

  task automatic write_all(longint unsigned f, longint unsigned d, longint unsigned lx,
                           longint unsigned ly, longint unsigned lt, longint unsigned h);
    write_reg(REG_GAIT_FREQ, f);
    write_reg(REG_STANCE_DUTY, d);
    write_reg(REG_STEP_LEN, lx);
    write_reg(REG_LAT_STEP, ly);
    write_reg(REG_TURN_STEP, lt);
    write_reg(REG_STEP_HEIGHT, h);
  endtask

  // Send one item; each cycle before it is idle with chance idle_pct.
  // start stays high across items unless an idle cycle comes between them.
  task automatic send_item(cmd_t c, bit have_expect, result_t want);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    target_queue.push_back(have_expect ? want : foot_target(c));
    items_sent++;
  endtask

  task automatic drain();
    int guard;
    start <= 1'b0;
    guard = 0;
    while (target_queue.size() != 0 && guard < 20 * LATENCY) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic cmd_t random_cmd();
    cmd_t c;
    c = '0;
    c.nominal_x      = 16'($urandom);
    c.nominal_y      = 16'($urandom);
    c.nominal_z      = 16'($urandom);
    c.phase_is_swing = 1'($urandom_range(1));
    case ($urandom_range(7))
      0:       c.phase_frac = 17'($urandom);              // includes above one
      1:       c.phase_frac = 17'd65536;
      default: c.phase_frac = 17'($urandom_range(65536));
    endcase
    // mostly realistic speeds, some full range
    if ($urandom_range(3) == 0) begin
      c.lin_vel_x = 16'($urandom);
      c.lin_vel_y = 16'($urandom);
      c.yaw_rate  = 16'($urandom);
    end else begin
      c.lin_vel_x = 16'($signed($urandom_range(4000)) - 2000);
      c.lin_vel_y = 16'($signed($urandom_range(4000)) - 2000);
      c.yaw_rate  = 16'($signed($urandom_range(4000)) - 2000);
    end
    return c;
  endfunction

  typedef struct {
    cmd_t    c;
    bit      typed;    // expected target typed in below
    result_t want;
  } stim_row_t;

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    int        phase;

    rst       = 1'b1;
    start     = 1'b0;
    cmd       = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    errors    = 0;
    items_sent   = 0;
    targets_seen = 0;
    idle_cycles  = 0;
    idle_pct     = 0;
    freq_mhz = 1000; duty_q16 = 32768; lim_x = 500; lim_y = 300;
    lim_turn = 2000; lift_peak = 300;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Zero velocity stance: target equals nominal.
    row.c = '0; row.typed = 1; row.want = '0;
    rows.push_back(row);
    row.c.nominal_x = 16'sh7fff; row.c.nominal_y = 16'sh8000; row.c.nominal_z = 16'sh7fff;
    row.want = '{16'sh7fff, 16'sh8000, 16'sh7fff};
    rows.push_back(row);
    // swing at peak on z max: lift pushes z past the top, saturates
    row.c.phase_is_swing = 1; row.c.phase_frac = 17'd32768;
    row.typed = 0;
    rows.push_back(row);
    // swing at fraction one, zero velocity: no lift, nominal back
    row.c = '0; row.c.phase_is_swing = 1; row.c.phase_frac = 17'd65536;
    row.c.nominal_z = -16'sd100; row.typed = 1; row.want = '{0, 0, -16'sd100};
    rows.push_back(row);
    // swing peak at reset height: z = 300
    row.c.phase_frac = 17'd32768; row.c.nominal_z = 0; row.want = '{0, 0, 16'sd300};
    rows.push_back(row);
    // remaining rows via predictor: velocity extremes, clamps, fraction beyond one
    row.typed = 0;
    for (int k = 0; k < 16; k++) begin
      row.c = '0;
      row.c.phase_is_swing = k[0];
      row.c.phase_frac = (k < 4) ? 17'd0 : (k < 8) ? 17'd65536 :
                         (k < 12) ? 17'h1ffff : 17'd16384;
      row.c.lin_vel_x = k[1] ? 16'sh7fff : 16'sh8000;
      row.c.lin_vel_y = k[2] ? 16'sh8000 : 16'sh7fff;
      row.c.yaw_rate  = k[3] ? 16'sh7fff : 16'sh8000;
      row.c.nominal_x = k[1] ? 16'sh7fff : 16'sh8000;
      row.c.nominal_y = k[2] ? 16'sh7fff : 16'sh8000;
      row.c.nominal_z = k[3] ? 16'sh7fff : 16'sh8000;
      rows.push_back(row);
    end
    foreach (rows[i]) send_item(rows[i].c, rows[i].typed, rows[i].want);
    drain();

    // Random phases: register setting and sender idling vary per phase
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_all(0, 65536, 32767, 32767, 32767, 32767);   // freq floor, duty one
        1: write_all(65535, 0, 0, 0, 0, 0);                   // max frequency, all else zero
        2: write_all(5, 131071, 32767, 32767, 32767, 32767);  // duty above one
        3: write_all(1000, 32768, 500, 300, 2000, 300);       // defaults
        default: write_all($urandom_range(65535), $urandom_range(131071),
                           $urandom_range(32767), $urandom_range(32767),
                           $urandom_range(32767), $urandom_range(32767));
      endcase
      write_reg(3'd6, $urandom);  // unused index, dropped
      write_reg(3'd7, $urandom);
      // receiver stall phase has nothing to stall: sender runs flat out there
      idle_pct = (phase % 4 == 1) ? 85 : (phase % 4 == 3) ? 10 : 0;
      for (int n = 0; n < N_RANDOM / 8; n++) send_item(random_cmd(), 0, '0);
      drain();
    end

    $display("covered %0d items, %0d targets checked, 8 register settings incl. extremes",
             items_sent, targets_seen);
    if (errors == 0 && target_queue.size() == 0)
      $display("[gait_foot_target_generator_core] OK");
    else begin
      if (target_queue.size() != 0)
        $error("%0d targets never arrived", target_queue.size());
      $display("[gait_foot_target_generator_core] ERROR");
    end
    $finish;
  end

endmodule
